### rtl/fmspg_pkg.sv
// Package for the framed multi-servo pulse generator.
// Holds shared constants, the queue word type and config register codes.
// No dependencies.
`default_nettype none

package fmspg_pkg;

  localparam int DefChannels = 5;

  localparam int PinsW    = 5;
  localparam int ChanOutW = 3;
  localparam int SlotW    = 15;
  localparam int WidthW   = 14;
  localparam int OffW     = 13;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 15;

  localparam logic [7:0]        StartMark   = 8'h53;
  localparam logic [7:0]        EndMark     = 8'h45;
  localparam logic [7:0]        MaxAngle    = 8'd180;
  localparam logic [WidthW-1:0] CentreWidth = 14'd7501;
  localparam logic [WidthW-1:0] WidthMax    = 14'd16383;

  localparam logic [SlotW-1:0]  SlotReset   = 15'd20096;
  localparam logic [WidthW-1:0] MinReset    = 14'd5001;

  // floor(250*a/9) ~ (a * AngleRecip) >> 16, at most one low
  localparam logic [20:0] AngleRecip = 21'd1820250;

  localparam logic [CfgIdxW-1:0] CfgSlotTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMinPulse  = 2'd1;

  typedef struct packed {
    logic            is_tick;
    logic            is_start;
    logic            is_end;
    logic [OffW-1:0] offset;
  } entry_t;

endpackage

`default_nettype wire

### rtl/fmspg_front.sv
// Front end: classifies each accepted word and converts the byte to a
// pulse width offset. Depends on fmspg_pkg.
`default_nettype none

module fmspg_front import fmspg_pkg::*; (
  input  wire logic       cmd,
  input  wire logic [7:0] rx_byte,
  output entry_t          entry
);

  logic [7:0]      angle;
  logic [28:0]     prod;
  logic [OffW-1:0] quot;
  logic [16:0]     scaled;
  logic [16:0]     rem;

  always_comb begin
    angle  = (rx_byte > MaxAngle) ? MaxAngle : rx_byte;
    prod   = 29'(angle) * 29'(AngleRecip);
    quot   = prod[28:16];
    scaled = (17'(angle) << 8) - (17'(angle) << 2) - (17'(angle) << 1);
    rem    = scaled - ((17'(quot) << 3) + 17'(quot));
    entry.is_tick  = cmd;
    entry.is_start = (rx_byte == StartMark);
    entry.is_end   = (rx_byte == EndMark);
    entry.offset   = (rem >= 17'd9) ? quot + 1'b1 : quot;
  end

endmodule

`default_nettype wire

### rtl/fmspg_queue.sv
// Two-word queue between front and back ends.
// Depends on fmspg_pkg for the word type.
`default_nettype none

module fmspg_queue import fmspg_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        not_full,
  input  wire logic   pop,
  output logic        not_empty,
  output entry_t      head
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

### rtl/fmspg_back.sv
// Back end: frame parser, width store, slot sequencer and result register.
// Depends on fmspg_pkg.
`default_nettype none

module fmspg_back import fmspg_pkg::*; #(
  parameter int CHANNELS = DefChannels
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [SlotW-1:0]  slot_ticks,
  input  wire logic [WidthW-1:0] min_pulse_ticks,
  input  wire logic              head_valid,
  input  wire entry_t            head,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output logic [PinsW-1:0]       servo_pins,
  output logic [ChanOutW-1:0]    active_channel,
  output logic                   frame_done,
  output logic                   frame_error
);

  localparam int ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ChW:0] ChanCount = (ChW + 1)'(CHANNELS);

  typedef enum logic [1:0] {PhIdle, PhAngles, PhEnd} phase_t;

  phase_t            phase;
  logic [ChW-1:0]    byte_index;
  logic [OffW-1:0]   angle_buf   [CHANNELS];
  logic [WidthW-1:0] pulse_width [CHANNELS];
  logic [ChW-1:0]    channel_now;
  logic [SlotW-1:0]  slot_count;
  logic [WidthW-1:0] pulse_left;
  logic [CHANNELS-1:0] pins;

  logic [CHANNELS-1:0] ch_mask;
  logic [WidthW-1:0]   left_next;
  logic [CHANNELS-1:0] pins_next;
  logic [SlotW-1:0]    slot_next;
  logic                slot_end;
  logic [ChW-1:0]      channel_next;
  logic                commit;
  logic [WidthW:0]     sum [CHANNELS];

  assign pop = head_valid && (!result_valid || result_ready);
  assign commit = pop && !head.is_tick && (phase == PhEnd) && head.is_end;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      ch_mask[i] = (channel_now == ChW'(i));
      sum[i] = (WidthW + 1)'(min_pulse_ticks) + (WidthW + 1)'(angle_buf[i]);
    end
    left_next = pulse_left;
    pins_next = pins;
    if (slot_count == '0) begin
      left_next = pulse_width[channel_now];
      pins_next = (left_next != '0) ? ch_mask : '0;
    end
    if (left_next != '0) begin
      left_next = left_next - 1'b1;
      if (left_next == '0) pins_next = pins_next & ~ch_mask;
    end
    slot_next = slot_count + 1'b1;
    slot_end  = (slot_next >= slot_ticks) || (slot_next == '0);
    channel_next = ((ChW + 1)'(channel_now) + 1'b1 >= ChanCount) ? '0
                                                                   : channel_now + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (pop && !head.is_tick && phase == PhAngles) begin
      angle_buf[byte_index] <= head.offset;
    end
    if (rst) begin
      phase        <= PhIdle;
      byte_index   <= '0;
      channel_now  <= '0;
      slot_count   <= '0;
      pulse_left   <= '0;
      pins         <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) pulse_width[i] <= CentreWidth;
    end else begin
      if (result_ready && !pop) result_valid <= 1'b0;
      if (pop) begin
        result_valid <= 1'b1;
        frame_done   <= commit;
        frame_error  <= !head.is_tick && (phase == PhEnd) && !head.is_end;
        if (head.is_tick) begin
          pulse_left     <= left_next;
          pins           <= pins_next;
          slot_count     <= slot_end ? '0 : slot_next;
          channel_now    <= slot_end ? channel_next : channel_now;
          active_channel <= ChanOutW'(slot_end ? channel_next : channel_now);
          servo_pins     <= PinsW'(pins_next);
        end else begin
          active_channel <= ChanOutW'(channel_now);
          servo_pins     <= PinsW'(pins);
          unique case (phase)
            PhAngles: begin
              if ((ChW + 1)'(byte_index) + 1'b1 >= ChanCount) begin
                phase      <= PhEnd;
                byte_index <= '0;
              end else begin
                byte_index <= byte_index + 1'b1;
              end
            end
            PhEnd: begin
              phase      <= PhIdle;
              byte_index <= '0;
            end
            default: begin
              if (head.is_start) begin
                phase      <= PhAngles;
                byte_index <= '0;
              end else begin
                phase <= PhIdle;
              end
            end
          endcase
          if (commit) begin
            for (int i = 0; i < CHANNELS; i++) begin
              pulse_width[i] <= (sum[i] > (WidthW + 1)'(WidthMax)) ? WidthMax
                                                                   : sum[i][WidthW-1:0];
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/framed_multi_servo_pulse_generator.sv
// Framed multi-servo pulse generator, top level: config registers, front
// end, queue and back end. Depends on fmspg_pkg and the fmspg_* modules.
//
// Each word is a serial byte (cmd 0) or a timer tick (cmd 1) and gives one
// result word. One word is accepted per cycle, a tick included, while the queue
// is not full; a result is presented from the result register behind the
// two-word queue, and a stalled result side fills the queue before ready
// drops. Frames are 'S', CHANNELS angle bytes, 'E'; a good end marker
// commits all widths at once. The config port is always ready and should be
// written only while no words are in flight.
`default_nettype none

module framed_multi_servo_pulse_generator import fmspg_pkg::*; #(
  parameter int CHANNELS = DefChannels
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire logic                cmd,
  input  wire logic [7:0]          rx_byte,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output logic [PinsW-1:0]         servo_pins,
  output logic [ChanOutW-1:0]      active_channel,
  output logic                     frame_done,
  output logic                     frame_error,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  logic [SlotW-1:0]  slot_ticks;
  logic [WidthW-1:0] min_pulse_ticks;
  entry_t            front_entry;
  entry_t            head;
  logic              head_valid;
  logic              pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks      <= SlotReset;
      min_pulse_ticks <= MinReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgSlotTicks: slot_ticks      <= cfg_data[SlotW-1:0];
        CfgMinPulse:  min_pulse_ticks <= cfg_data[WidthW-1:0];
        default: ;
      endcase
    end
  end

  fmspg_front u_front (
    .cmd     (cmd),
    .rx_byte (rx_byte),
    .entry   (front_entry)
  );

  fmspg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid),
    .push_data (front_entry),
    .not_full  (item_ready),
    .pop       (pop),
    .not_empty (head_valid),
    .head      (head)
  );

  fmspg_back #(.CHANNELS(CHANNELS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .slot_ticks      (slot_ticks),
    .min_pulse_ticks (min_pulse_ticks),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .servo_pins      (servo_pins),
    .active_channel  (active_channel),
    .frame_done      (frame_done),
    .frame_error     (frame_error)
  );

  a_done_err_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(frame_done && frame_error))
    else $error("frame_done and frame_error both set");

  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(active_channel) < CHANNELS))
    else $error("active_channel out of range");

  a_pins_onehot: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0(servo_pins))
    else $error("more than one servo pin high");

  a_tick_no_flag: assert property (@(posedge clk) disable iff (rst)
    (pop && head.is_tick) |=> !frame_done && !frame_error)
    else $error("frame flag on a tick");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Testbench for framed_multi_servo_pulse_generator: drives byte and tick words
// with random idling and stalls, predicts every result word in-line and checks it.
// Depends on fmspg_pkg and the RTL of the block.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fmspg_pkg::*;

  localparam int NumChan    = DefChannels;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 80;
  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;
  localparam logic [7:0] StallPattern = 8'b1011_0010;

  typedef enum logic [1:0] {
    WaitStart  = 2'd0,
    TakeAngles = 2'd1,
    WaitEnd    = 2'd2
  } parse_phase_t;

  typedef enum int {RxOpen, RxCoin, RxSparse, RxPattern} stall_mode_t;
  typedef enum int {NoPressure, HoldResults, PauseForDrain} pressure_t;

  typedef struct packed {
    logic [PinsW-1:0]    pins;
    logic [ChanOutW-1:0] chan;
    logic                done;
    logic                err;
  } pin_state_t;

  class pulse_tracker;
    logic [SlotW-1:0]    slot_len;
    logic [WidthW-1:0]   base_width;
    parse_phase_t        phase;
    logic [2:0]          angle_pos;
    logic [7:0]          angles [NumChan];
    logic [WidthW-1:0]   widths [NumChan];
    logic [ChanOutW-1:0] chan;
    logic [SlotW-1:0]    slot_pos;
    logic [WidthW-1:0]   remaining;
    logic [PinsW-1:0]    pins;
    pin_state_t          due [$];
    int                  errors;

    function new();
      slot_len = SlotReset;
      base_width = MinReset;
      phase = WaitStart;
      angle_pos = '0;
      foreach (widths[k]) begin
        angles[k] = '0;
        widths[k] = CentreWidth;
      end
      chan = '0;
      slot_pos = '0;
      remaining = '0;
      pins = '0;
      errors = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgSlotTicks: slot_len = data[SlotW-1:0];
        CfgMinPulse:  base_width = data[WidthW-1:0];
        default: ;
      endcase
    endfunction

    function logic [WidthW-1:0] angle_width(logic [7:0] angle);
      int a;
      int w;
      a = (angle > MaxAngle) ? MaxAngle : angle;
      w = base_width + (250 * a) / 9;
      if (w > WidthMax) w = WidthMax;
      return w[WidthW-1:0];
    endfunction

    function void take_word(logic is_tick, logic [7:0] b);
      pin_state_t st;
      logic [PinsW-1:0] lane;
      st.done = 1'b0;
      st.err = 1'b0;
      lane = '0;
      lane[chan] = 1'b1;
      if (is_tick == CmdByte) begin
        case (phase)
          TakeAngles: begin
            angles[angle_pos] = b;
            if (angle_pos + 1 >= NumChan) begin
              phase = WaitEnd;
              angle_pos = '0;
            end else begin
              angle_pos = angle_pos + 1'b1;
            end
          end
          WaitEnd: begin
            if (b == EndMark) begin
              foreach (widths[k]) widths[k] = angle_width(angles[k]);
              st.done = 1'b1;
            end else begin
              st.err = 1'b1;
            end
            phase = WaitStart;
            angle_pos = '0;
          end
          default: begin
            phase = (b == StartMark) ? TakeAngles : WaitStart;
            angle_pos = '0;
          end
        endcase
      end else begin
        if (slot_pos == 0) begin
          remaining = widths[chan];
          pins = (remaining != 0) ? lane : '0;
        end
        if (remaining != 0) begin
          remaining--;
          if (remaining == 0) pins &= ~lane;
        end
        slot_pos++;
        if (slot_pos >= slot_len || slot_pos == 0) begin
          slot_pos = '0;
          chan = (chan + 1 >= NumChan) ? '0 : chan + 1'b1;
        end
      end
      st.pins = pins;
      st.chan = chan;
      due.push_back(st);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task match_word(logic [PinsW-1:0] p, logic [ChanOutW-1:0] c, logic d, logic e);
      pin_state_t st;
      if (due.size() == 0) begin
        report("result word with nothing due, servo_pins", p, -1);
      end else begin
        st = due.pop_front();
        if (p !== st.pins) report("servo_pins", p, st.pins);
        if (c !== st.chan) report("active_channel", c, st.chan);
        if (d !== st.done) report("frame_done", d, st.done);
        if (e !== st.err) report("frame_error", e, st.err);
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  logic                cmd;
  logic [7:0]          rx_byte;
  logic                result_valid;
  logic                result_ready;
  logic [PinsW-1:0]    servo_pins;
  logic [ChanOutW-1:0] active_channel;
  logic                frame_done;
  logic                frame_error;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  pulse_tracker tracker;
  bit           hold_request;
  bit           steady;
  int           burst_left;
  int unsigned  cycle_count = 0;

  logic [8:0] opening [28] = '{
    {CmdTick, 8'hA5}, {CmdByte, 8'h00}, {CmdByte, EndMark}, {CmdByte, StartMark},
    {CmdByte, 8'd0}, {CmdByte, MaxAngle}, {CmdByte, 8'd181}, {CmdByte, StartMark},
    {CmdByte, EndMark}, {CmdByte, EndMark}, {CmdTick, 8'h5A}, {CmdByte, StartMark},
    {CmdByte, 8'd255}, {CmdByte, 8'd1}, {CmdByte, 8'd2}, {CmdByte, 8'd3},
    {CmdByte, 8'd90}, {CmdByte, StartMark}, {CmdByte, EndMark}, {CmdByte, StartMark},
    {CmdByte, 8'd0}, {CmdByte, 8'd0}, {CmdByte, 8'd0}, {CmdByte, 8'd0},
    {CmdByte, 8'd0}, {CmdByte, 8'hE2}, {CmdByte, 8'hB3}, {CmdTick, 8'hFF}
  };

  framed_multi_servo_pulse_generator dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .cmd            (cmd),
    .rx_byte        (rx_byte),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .servo_pins     (servo_pins),
    .active_channel (active_channel),
    .frame_done     (frame_done),
    .frame_error    (frame_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready)
        tracker.match_word(servo_pins, active_channel, frame_done, frame_error);
      if (item_valid && item_ready) tracker.take_word(cmd, rx_byte);
      if (cfg_valid && cfg_ready) tracker.set_register(cfg_index, cfg_data);
    end
  end

  // result side: stall modes in stretches, plus the long hold-off on request
  initial begin
    stall_mode_t mode;
    int stretch;
    int step;
    result_ready = 1'b0;
    mode = RxOpen;
    stretch = 0;
    step = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      if (stretch == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        stretch = $urandom_range(8, 60);
      end
      stretch--;
      step++;
      case (mode)
        RxOpen:   result_ready <= 1'b1;
        RxCoin:   result_ready <= 1'($urandom_range(0, 1));
        RxSparse: result_ready <= ($urandom_range(0, 3) == 0);
        default:  result_ready <= StallPattern[step % 8];
      endcase
    end
  end

  task automatic send_word(logic c, logic [7:0] b);
    item_valid <= 1'b1;
    cmd <= c;
    rx_byte <= b;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic idle_for(int n);
    item_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic offer(logic c, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0 && !steady) idle_for(gap);
    end
    burst_left--;
    send_word(c, b);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (tracker.due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // mostly whole frames with ticks mixed in; some bad ends, stray and cut-short frames
  task automatic random_phase(int words, pressure_t pressure);
    int sent;
    int kind;
    int n;
    int k;
    bit mid_done;
    logic [7:0] b;
    sent = 0;
    mid_done = 0;
    while (sent < words) begin
      if (!mid_done && sent >= words / 2) begin
        mid_done = 1;
        if (pressure == HoldResults) begin
          hold_request = 1'b1;
          steady = 1'b1;
        end else if (pressure == PauseForDrain) begin
          wait_drained();
        end
      end
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        n = $urandom_range(1, 8);
        repeat (n) offer(CmdTick, 8'($urandom));
        sent += n;
      end else if (kind == 8) begin
        b = 8'($urandom);
        if (b == StartMark) b = 8'h00;
        offer(CmdByte, b);
        sent++;
      end else begin
        offer(CmdByte, StartMark);
        n = (kind == 9) ? $urandom_range(0, NumChan - 1) : NumChan;
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 2) == 0) begin
            offer(CmdTick, 8'($urandom));
            sent++;
          end
          case ($urandom_range(0, 7))
            0:       b = 8'd0;
            1:       b = MaxAngle;
            2:       b = 8'($urandom_range(181, 255));
            3, 4:    b = 8'($urandom_range(0, 3));
            default: b = 8'($urandom);
          endcase
          offer(CmdByte, b);
        end
        if (kind <= 6) begin
          offer(CmdByte, EndMark);
        end else if (kind == 7) begin
          b = 8'($urandom);
          if (b == EndMark) b = StartMark;
          offer(CmdByte, b);
        end
        sent += (kind == 9) ? n + 1 : n + 2;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    int ph;
    int guard;
    logic [CfgDataW-1:0] slot;
    logic [CfgDataW-1:0] minp;
    pressure_t pressure;
    tracker = new();
    rst = 1'b1;
    item_valid = 1'b0;
    cmd = 1'b0;
    rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_request = 1'b0;
    steady = 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening[i]) offer(opening[i][8], opening[i][7:0]);

    for (ph = 0; ph < 10; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          slot = 15'd10002;
          minp = 15'd10000;
        end
        1: begin
          slot = 15'd32767;
          minp = 15'd1;
        end
        2: begin
          slot = 15'd0;
          minp = 15'd0;
        end
        3: begin
          slot = 15'd1;
          minp = 15'h7FFF;
        end
        4, 5, 6, 7: begin
          slot = 15'($urandom_range(2, 60));
          minp = 15'($urandom_range(0, 40));
        end
        default: begin
          slot = 15'($urandom_range(60, 400));
          minp = 15'($urandom_range(0, 300));
        end
      endcase
      write_reg(CfgSlotTicks, slot);
      write_reg(CfgMinPulse, minp);
      if (ph == 2) write_reg(CfgSpareA, 15'($urandom));
      if (ph == 7) write_reg(CfgSpareB, 15'($urandom));
      pressure = (ph == 5) ? HoldResults : (ph == 6) ? PauseForDrain : NoPressure;
      random_phase(50, pressure);
    end

    item_valid <= 1'b0;
    guard = 0;
    while (tracker.due.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (tracker.due.size() != 0)
      tracker.report("result words never delivered", 0, tracker.due.size());
    if (tracker.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fmspg_pkg.sv
rtl/fmspg_front.sv
rtl/fmspg_queue.sv
rtl/fmspg_back.sv
rtl/framed_multi_servo_pulse_generator.sv
tb/sv/testbench.sv
